// ===== rtl/lbps_pkg.sv =====
// Shared types and codes for the lane boundary profile sampler.
`timescale 1ns / 1ps
package lbps_pkg;
	typedef logic signed [31:0] q16_t;

	localparam logic [1:0] REQ_ROAD   = 2'd0;
	localparam logic [1:0] REQ_PROF   = 2'd1;
	localparam logic [1:0] REQ_STYLE  = 2'd2;
	localparam logic [1:0] REQ_SAMPLE = 2'd3;

	localparam int STYLE_ATTRS = 7;
	// Style codes below -0.5 mark padding slots.
	localparam q16_t PAD_LIMIT = -32'sd32768;
	// One half in Q0.16, for nearest-row rounding.
	localparam logic [15:0] HALF_Q16 = 16'h8000;
endpackage

// ===== rtl/lbps_lerp.sv =====
// Shared multiply-add unit: lo + ((hi - lo) * u) >> 16, product registered.
`timescale 1ns / 1ps
module lbps_lerp
	import lbps_pkg::*;
(
	input  logic        clk,
	input  logic        en,
	input  q16_t        lo,
	input  q16_t        hi,
	input  logic [15:0] u,
	output q16_t        pos
);
	logic signed [32:0] diff;
	logic signed [49:0] prod_q;
	q16_t               lo_q;

	assign diff = $signed({hi[31], hi}) - $signed({lo[31], lo});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= diff * $signed({1'b0, u});
			lo_q   <= lo;
		end
	end

	// Arithmetic shift floors toward minus infinity.
	assign pos = lo_q + q16_t'(prod_q >>> 16);
endmodule

// ===== rtl/lane_boundary_profile_sampler.sv =====
// Top level of the lane boundary profile sampler: stores, sequencer and result buffer.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------------
//  cfg      | in        | cfg_valid/cfg_ready  | cfg_data (style_rows_in_use)
//  in       | in        | in_valid/in_ready    | req_type .. value_g
//  out      | out       | out_valid/out_ready  | position .. wear, found, last
//
// Writes are taken in the idle state and do not leave it; the block is ready again the next cycle.
// A sample walks the road, row and style index lookups (DESC, LOC, ROWS, SIDX, SROW), then
// per slot CHK, RD, MUL and PUT through the shared multiply-add unit (no PUT for a padding
// slot), and ends in FIN. Registered memory reads set the slot loop.
// Reset clears the road table (valid bits) and sets style_rows_in_use to 1; no clearing pass.
// A stalled output holds the sequencer only when a second result or the final one must move.
`timescale 1ns / 1ps
module lane_boundary_profile_sampler
	import lbps_pkg::*;
#(
	parameter int MAX_BOUNDARIES = 8,
	parameter int PROFILE_ROWS   = 1024,
	parameter int STYLE_ROWS     = 256,
	parameter int MAX_ROADS      = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [8:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [9:0]  target_index,
	input  logic [3:0]  slot,
	input  logic [25:0] row_coord,
	input  logic [3:0]  max_count,
	input  q16_t        value_a,
	input  q16_t        value_b,
	input  q16_t        value_c,
	input  q16_t        value_d,
	input  q16_t        value_e,
	input  q16_t        value_f,
	input  q16_t        value_g,
	output logic        out_valid,
	input  logic        out_ready,
	output q16_t        position,
	output q16_t        style_code,
	output q16_t        line_width,
	output q16_t        line_gap,
	output q16_t        color_code,
	output q16_t        dash_on,
	output q16_t        dash_off,
	output q16_t        wear,
	output logic        found,
	output logic        last
);
	localparam int PW   = (PROFILE_ROWS > 1) ? $clog2(PROFILE_ROWS) : 1;
	localparam int CTW  = $clog2(PROFILE_ROWS + 1);
	localparam int SW   = (STYLE_ROWS > 1) ? $clog2(STYLE_ROWS) : 1;
	localparam int RW   = (MAX_ROADS > 1) ? $clog2(MAX_ROADS) : 1;
	localparam int KW   = $clog2(MAX_BOUNDARIES + 1);
	localparam int PAW  = (PROFILE_ROWS * MAX_BOUNDARIES > 1) ?
		$clog2(PROFILE_ROWS * MAX_BOUNDARIES) : 1;
	localparam int SAW  = (STYLE_ROWS * MAX_BOUNDARIES > 1) ?
		$clog2(STYLE_ROWS * MAX_BOUNDARIES) : 1;
	localparam int IW   = (PW > 10) ? PW : 10;
	localparam int LW   = IW + 18;
	localparam int AW   = STYLE_ATTRS * 32;

	typedef enum logic [3:0] {
		S_IDLE, S_DESC, S_LOC, S_ROWS, S_SIDX, S_SROW, S_CHK, S_RD, S_MUL, S_PUT, S_FIN
	} state_t;

	state_t state_q;

	// Stores
	logic [PW-1:0]  road_base_mem [MAX_ROADS];
	logic [CTW-1:0] road_cnt_mem  [MAX_ROADS];
	logic [MAX_ROADS-1:0] road_vld_q;
	logic [31:0]    prof_mem  [PROFILE_ROWS * MAX_BOUNDARIES];
	logic [SW-1:0]  sidx_mem  [PROFILE_ROWS];
	logic [AW-1:0]  style_mem [STYLE_ROWS * MAX_BOUNDARIES];

	logic [8:0]     rows_in_use_q;

	// Latched sample fields and lookup results
	logic [9:0]     tgt_q;
	logic [25:0]    coord_q;
	logic [3:0]     maxc_q;
	logic [PW-1:0]  base_rd_q;
	logic [CTW-1:0] cnt_rd_q;
	logic           hit_rd_q;
	logic [IW+15:0] local_q;
	logic [PW-1:0]  glo_q, ghi_q, gnear_q;
	logic [15:0]    u_q;
	logic [SW-1:0]  sidx_rd_q;
	logic [SW-1:0]  srow_q;
	logic [KW-1:0]  k_q;
	logic [KW-1:0]  cnt_q;
	q16_t           pr_lo_q, pr_hi_q;
	logic [AW-1:0]  st_q;

	// Pending result: released once the next one shows up or the sample ends
	logic           pend_vld_q;
	q16_t           pend_pos_q;
	logic [AW-1:0]  pend_attr_q;

	logic           out_vld_q;
	q16_t           out_pos_q;
	logic [AW-1:0]  out_attr_q;
	logic           out_found_q, out_last_q;

	logic in_acc;
	assign in_acc    = in_valid && in_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;

	// Write decode
	logic           road_ok, prof_ok, style_ok;
	logic [RW-1:0]  road_wa;
	logic [PW-1:0]  base_w;
	logic [CTW-1:0] cnt_w;
	logic [SW-1:0]  sidx_w;
	logic [PAW-1:0] prof_wa;
	logic [SAW-1:0] style_wa;

	assign road_ok  = ({1'b0, target_index} < 11'(MAX_ROADS));
	assign prof_ok  = ({7'b0, target_index} < 17'(PROFILE_ROWS));
	assign style_ok = ({3'b0, target_index} < 13'(STYLE_ROWS)) &&
		({1'b0, slot} < 5'(MAX_BOUNDARIES));
	assign road_wa  = target_index[RW-1:0];
	assign prof_wa  = PAW'(target_index) * PAW'(MAX_BOUNDARIES) + PAW'(slot);
	assign style_wa = SAW'(target_index) * SAW'(MAX_BOUNDARIES) + SAW'(slot);

	always_comb begin
		if (value_a < 0)
			base_w = '0;
		else if (value_a > $signed(32'(PROFILE_ROWS - 1)))
			base_w = PW'(PROFILE_ROWS - 1);
		else
			base_w = value_a[PW-1:0];
		if (value_b < 0)
			cnt_w = '0;
		else if (value_b > $signed(32'(PROFILE_ROWS)))
			cnt_w = CTW'(PROFILE_ROWS);
		else
			cnt_w = value_b[CTW-1:0];
		if (value_a < 0)
			sidx_w = '0;
		else if (value_a > $signed(32'(STYLE_ROWS - 1)))
			sidx_w = SW'(STYLE_ROWS - 1);
		else
			sidx_w = value_a[SW-1:0];
	end

	// Sample address math
	logic signed [LW-1:0] local_raw, top_s;
	logic [IW+15:0]  local_cl;
	logic [PW:0]     nm1;
	logic [PW:0]     lo_w, hi_w;
	logic [IW:0]     near_w;
	logic [PW:0]     near_cl;
	logic [PW:0]     glo_s, ghi_s, gnear_s;
	logic [12:0]     riu;
	logic [SW-1:0]   srow_w;
	logic [PAW-1:0]  pa_lo, pa_hi;
	logic [SAW-1:0]  sa;

	assign local_raw = $signed(LW'(coord_q)) - $signed(LW'({base_rd_q, 16'b0}));
	assign top_s     = $signed(LW'({(cnt_rd_q - CTW'(1)), 16'b0}));
	assign local_cl  = (local_raw < 0) ? '0 :
		(local_raw > top_s) ? top_s[IW+15:0] : local_raw[IW+15:0];

	assign nm1    = (PW + 1)'(cnt_rd_q) - (PW + 1)'(1);
	assign lo_w   = (PW + 1)'(local_q[IW+15:16]);
	assign hi_w   = (lo_w + (PW + 1)'(1) > nm1) ? nm1 : lo_w + (PW + 1)'(1);
	assign near_w = (IW + 1)'((LW - 1)'(local_q) + (LW - 1)'(HALF_Q16) >> 16);
	assign near_cl = ((IW + 2)'(near_w) > (IW + 2)'(nm1)) ? nm1 : (PW + 1)'(near_w);

	function automatic logic [PW:0] wrap_row(input logic [PW-1:0] b, input logic [PW:0] r);
		logic [PW+1:0] s;
		s = (PW + 2)'(b) + (PW + 2)'(r);
		if (s >= (PW + 2)'(PROFILE_ROWS))
			s = s - (PW + 2)'(PROFILE_ROWS);
		return s[PW:0];
	endfunction

	function automatic logic road_ok_q(input logic [9:0] t);
		return {1'b0, t} < 11'(MAX_ROADS);
	endfunction

	assign glo_s   = wrap_row(base_rd_q, lo_w);
	assign ghi_s   = wrap_row(base_rd_q, hi_w);
	assign gnear_s = wrap_row(base_rd_q, near_cl);

	always_comb begin
		if (rows_in_use_q == 9'd0)
			riu = 13'd1;
		else if (13'(rows_in_use_q) > 13'(STYLE_ROWS))
			riu = 13'(STYLE_ROWS);
		else
			riu = 13'(rows_in_use_q);
		if (13'(sidx_rd_q) > riu - 13'd1)
			srow_w = SW'(riu - 13'd1);
		else
			srow_w = sidx_rd_q;
	end

	assign pa_lo = PAW'(glo_q) * PAW'(MAX_BOUNDARIES) + PAW'(k_q);
	assign pa_hi = PAW'(ghi_q) * PAW'(MAX_BOUNDARIES) + PAW'(k_q);
	assign sa    = SAW'(srow_q) * SAW'(MAX_BOUNDARIES) + SAW'(k_q);

	// Shared multiply-add unit
	q16_t lerp_pos;
	logic lerp_en;
	assign lerp_en = (state_q == S_MUL);

	lbps_lerp u_lerp (
		.clk (clk),
		.en  (lerp_en),
		.lo  (pr_lo_q),
		.hi  (pr_hi_q),
		.u   (u_q),
		.pos (lerp_pos)
	);

	logic is_pad, out_free, out_load;
	assign is_pad   = $signed(st_q[31:0]) < PAD_LIMIT;
	assign out_free = !out_vld_q || out_ready;
	assign out_load = ((state_q == S_PUT) && pend_vld_q && out_free) ||
		((state_q == S_FIN) && out_free);

	// Memories
	always_ff @(posedge clk) begin
		if (in_acc && req_type == REQ_ROAD && road_ok) begin
			road_base_mem[road_wa] <= base_w;
			road_cnt_mem[road_wa]  <= cnt_w;
		end
		if (state_q == S_DESC) begin
			base_rd_q <= road_base_mem[tgt_q[RW-1:0]];
			cnt_rd_q  <= road_cnt_mem[tgt_q[RW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && req_type == REQ_PROF && prof_ok) begin
			if ({1'b0, slot} < 5'(MAX_BOUNDARIES))
				prof_mem[prof_wa] <= value_a;
			else if ({1'b0, slot} == 5'(MAX_BOUNDARIES))
				sidx_mem[PW'(target_index)] <= sidx_w;
		end
		if (state_q == S_SIDX)
			sidx_rd_q <= sidx_mem[gnear_q];
		if (state_q == S_RD) begin
			pr_lo_q <= prof_mem[pa_lo];
			pr_hi_q <= prof_mem[pa_hi];
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && req_type == REQ_STYLE && style_ok)
			style_mem[style_wa] <= {value_g, value_f, value_e, value_d, value_c, value_b, value_a};
		if (state_q == S_RD)
			st_q <= style_mem[sa];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			road_vld_q    <= '0;
			rows_in_use_q <= 9'd1;
		end else begin
			if (in_acc && req_type == REQ_ROAD && road_ok)
				road_vld_q[road_wa] <= 1'b1;
			if (cfg_valid && cfg_ready)
				rows_in_use_q <= cfg_data;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			tgt_q       <= '0;
			coord_q     <= '0;
			maxc_q      <= '0;
			hit_rd_q    <= 1'b0;
			local_q     <= '0;
			glo_q       <= '0;
			ghi_q       <= '0;
			gnear_q     <= '0;
			u_q         <= '0;
			srow_q      <= '0;
			k_q         <= '0;
			cnt_q       <= '0;
			pend_vld_q  <= 1'b0;
			pend_pos_q  <= '0;
			pend_attr_q <= '0;
			out_vld_q   <= 1'b0;
			out_pos_q   <= '0;
			out_attr_q  <= '0;
			out_found_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else begin
			if (out_load)
				out_vld_q <= 1'b1;
			else if (out_ready)
				out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc && req_type == REQ_SAMPLE) begin
						tgt_q   <= target_index;
						coord_q <= row_coord;
						maxc_q  <= max_count;
						state_q <= S_DESC;
					end
				end
				S_DESC: begin
					hit_rd_q <= road_ok_q(tgt_q) && road_vld_q[tgt_q[RW-1:0]];
					state_q  <= S_LOC;
				end
				S_LOC: begin
					local_q <= local_cl;
					if (!hit_rd_q || cnt_rd_q == '0)
						state_q <= S_FIN;
					else
						state_q <= S_ROWS;
				end
				S_ROWS: begin
					glo_q   <= glo_s[PW-1:0];
					ghi_q   <= ghi_s[PW-1:0];
					gnear_q <= gnear_s[PW-1:0];
					u_q     <= local_q[15:0];
					state_q <= S_SIDX;
				end
				S_SIDX: begin
					state_q <= S_SROW;
				end
				S_SROW: begin
					srow_q  <= srow_w;
					k_q     <= '0;
					cnt_q   <= '0;
					state_q <= S_CHK;
				end
				S_CHK: begin
					if ((KW + 1)'(k_q) < (KW + 1)'(MAX_BOUNDARIES) &&
						(KW + 5)'(cnt_q) < (KW + 5)'(maxc_q))
						state_q <= S_RD;
					else
						state_q <= S_FIN;
				end
				S_RD: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					if (is_pad) begin
						k_q     <= k_q + KW'(1);
						state_q <= S_CHK;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					// Release the older result before taking the new one
					if (!pend_vld_q || out_free) begin
						if (pend_vld_q) begin
							out_pos_q   <= pend_pos_q;
							out_attr_q  <= pend_attr_q;
							out_found_q <= 1'b1;
							out_last_q  <= 1'b0;
						end
						pend_vld_q  <= 1'b1;
						pend_pos_q  <= lerp_pos;
						pend_attr_q <= st_q;
						k_q         <= k_q + KW'(1);
						cnt_q       <= cnt_q + KW'(1);
						state_q     <= S_CHK;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_last_q  <= 1'b1;
						out_found_q <= pend_vld_q;
						out_pos_q   <= pend_vld_q ? pend_pos_q : '0;
						out_attr_q  <= pend_vld_q ? pend_attr_q : '0;
						pend_vld_q  <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_vld_q;
	assign position   = out_pos_q;
	assign style_code = out_attr_q[31:0];
	assign line_width = out_attr_q[63:32];
	assign line_gap   = out_attr_q[95:64];
	assign color_code = out_attr_q[127:96];
	assign dash_on    = out_attr_q[159:128];
	assign dash_off   = out_attr_q[191:160];
	assign wear       = out_attr_q[223:192];
	assign found      = out_found_q;
	assign last       = out_last_q;

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_vld_q)
		else $error("pending result left over after a sample");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CHK |-> (KW + 5)'(cnt_q) <= (KW + 5)'(maxc_q))
		else $error("emitted more boundaries than max_count");

	a_sample_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && req_type == REQ_SAMPLE |=> state_q == S_DESC)
		else $error("sample transaction did not start the sequencer");

	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && req_type != REQ_SAMPLE |=> state_q == S_IDLE)
		else $error("write transaction left the block busy");

	a_notfound_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> last)
		else $error("not-found result without last");
endmodule
